FILE: hdl/maq_pkg.sv
// Package for the motion alarm qualifier: mode encoding, register indexes,
// register reset values and the configuration bundle used by maq_cfg,
// maq_core and the top level. No dependencies.
`default_nettype none

package maq_pkg;

  localparam int unsigned THRESH_W  = 10;
  localparam int unsigned IDLE_S_W  = 16;
  localparam int unsigned IDLE_MS_W = 26;  // 65535 s * 1000 fits in 26 bits
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [THRESH_W-1:0]  THRESH_RESET = THRESH_W'(200);
  localparam logic [IDLE_MS_W-1:0] MS_PER_S     = IDLE_MS_W'(1000);
  localparam logic [IDLE_MS_W-1:0] IDLE_MS_RESET = IDLE_MS_W'(10 * 1000);

  localparam logic [CFG_IDX_W-1:0] REG_SENSE_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_SECONDS    = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    MODE_UNINIT = 2'd0,
    MODE_STAB   = 2'd1,
    MODE_IDLE   = 2'd2,
    MODE_ALARM  = 2'd3
  } mode_e;

  // Live configuration; the idle time is kept in milliseconds.
  typedef struct packed {
    logic [THRESH_W-1:0]  threshold;
    logic [IDLE_MS_W-1:0] idle_ms;
  } cfg_t;

endpackage : maq_pkg

`default_nettype wire

FILE: hdl/maq_cfg.sv
// Configuration registers of the motion alarm qualifier.
// Depends on maq_pkg for register indexes, widths and reset values.
`default_nettype none

module maq_cfg
  import maq_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_wdata_i,
  output cfg_t                      cfg_o
);

  logic [THRESH_W-1:0]  threshold_q, threshold_d;
  logic [IDLE_MS_W-1:0] idle_ms_q, idle_ms_d;
  logic [IDLE_MS_W-1:0] idle_ms_prod;

  // The idle time is converted to milliseconds when it is written, so the
  // per-beat test is a plain compare against the elapsed time.
  assign idle_ms_prod = IDLE_MS_W'(cfg_wdata_i[IDLE_S_W-1:0]) * MS_PER_S;

  always_comb begin
    threshold_d = threshold_q;
    idle_ms_d   = idle_ms_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SENSE_THRESHOLD: threshold_d = cfg_wdata_i[THRESH_W-1:0];
        REG_IDLE_SECONDS:    idle_ms_d   = idle_ms_prod;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESH_RESET;
      idle_ms_q   <= IDLE_MS_RESET;
    end else begin
      threshold_q <= threshold_d;
      idle_ms_q   <= idle_ms_d;
    end
  end

  assign cfg_o.threshold = threshold_q;
  assign cfg_o.idle_ms   = idle_ms_q;

endmodule : maq_cfg

`default_nettype wire

FILE: hdl/maq_core.sv
// Level detection and four-state mode machine of the motion alarm qualifier.
// Depends on maq_pkg for the mode encoding and the configuration bundle.
`default_nettype none

module maq_core
  import maq_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   step_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  input  wire logic [TIME_W-1:0]      now_ms_i,
  input  wire cfg_t                   cfg_i,
  output logic [1:0]                  status_o,
  output logic                        changed_o
);

  localparam int unsigned CMP_W = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;

  mode_e               mode_q, mode_d;
  logic                last_level_q, last_level_d;
  logic [TIME_W-1:0]   event_time_q, event_time_d;
  logic                level;
  logic [TIME_W-1:0]   elapsed;
  logic                held;

  assign level   = CMP_W'(sample_i) > CMP_W'(cfg_i.threshold);
  // Wrapping difference; floor(elapsed / 1000) >= s is the same as
  // elapsed >= s * 1000.
  assign elapsed = now_ms_i - event_time_q;
  assign held    = elapsed >= TIME_W'(cfg_i.idle_ms);

  // Next mode.
  always_comb begin
    mode_d = mode_q;
    unique case (mode_q) inside
      MODE_UNINIT: mode_d = MODE_STAB;
      MODE_STAB, MODE_ALARM: begin
        if (level == last_level_q && !level && held) mode_d = MODE_IDLE;
      end
      MODE_IDLE: begin
        if (level) mode_d = MODE_ALARM;
      end
      default: mode_d = mode_q;
    endcase
  end

  // Level history and event timer.
  always_comb begin
    last_level_d = last_level_q;
    event_time_d = event_time_q;
    unique case (mode_q) inside
      MODE_UNINIT: begin
        last_level_d = level;
        event_time_d = now_ms_i;
      end
      MODE_STAB, MODE_ALARM: begin
        if (level != last_level_q) begin
          last_level_d = level;
          event_time_d = now_ms_i;
        end
      end
      MODE_IDLE: begin
        if (level) begin
          last_level_d = 1'b1;
          event_time_d = now_ms_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_UNINIT;
      last_level_q <= 1'b0;
      event_time_q <= '0;
    end else if (step_i) begin
      mode_q       <= mode_d;
      last_level_q <= last_level_d;
      event_time_q <= event_time_d;
    end
  end

  assign status_o  = mode_d;
  assign changed_o = (mode_d != mode_q);

endmodule : maq_core

`default_nettype wire

FILE: hdl/motion_alarm_qualifier_top.sv
// Top level of the motion alarm qualifier: input register, result register
// and handshake control around maq_cfg and maq_core. Depends on maq_pkg.
//
// Usage: each input beat carries one sensor sample and the current time in
// milliseconds. The sample is compared with sense_threshold to give a motion
// level, and a mode machine (uninitialized, stabilizing, idle, alarm) tracks
// that level. Exactly one result beat follows each input beat, in order,
// carrying the mode after the beat and a flag that is high when the beat
// changed the mode.
// Both channels use valid and stall; a beat moves at a clock edge with valid
// high and stall low. A beat is captured in the input register, evaluated
// against the mode state and lands in the result register. One beat per
// cycle is sustained while the receiver does not stall: the state update
// through the mode machine is the only loop, and the result register lets
// a new beat enter while a finished result waits. When the receiver stalls,
// the result holds steady and the input register fills; input stall then
// rises until the result is taken.
// The configuration port is a plain write port (register 0 threshold,
// register 1 idle seconds); write it only while no beat is in flight.
// Reset (asynchronous, active low) empties both registers, returns the mode
// to uninitialized and restores threshold 200 and idle time 10 seconds.
`default_nettype none

module motion_alarm_qualifier_top
  import maq_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CFG_DAT_W-1:0]   cfg_wdata_i,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  input  wire logic [TIME_W-1:0]      now_ms_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [1:0]                  status_o,
  output logic                        status_changed_o
);

  cfg_t                   cfg;
  logic                   in_accept;
  logic                   advance;
  logic                   s1_valid_q, s1_valid_d;
  logic [SAMPLE_BITS-1:0] s1_sample_q;
  logic [TIME_W-1:0]      s1_now_q;
  logic                   out_valid_q, out_valid_d;
  logic [1:0]             status_q, status_nx;
  logic                   changed_q, changed_nx;

  maq_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // The held beat is evaluated whenever the result register is free or is
  // being emptied in this same cycle.
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  maq_core #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .sample_i  (s1_sample_q),
    .now_ms_i  (s1_now_q),
    .cfg_i     (cfg),
    .status_o  (status_nx),
    .changed_o (changed_nx)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (advance) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_sample_q <= sample_i;
      s1_now_q    <= now_ms_i;
    end
    if (advance) begin
      status_q  <= status_nx;
      changed_q <= changed_nx;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign status_changed_o = changed_q;

endmodule : motion_alarm_qualifier_top

`default_nettype wire

FILE: hdl/maq_chk.sv
// Port-level checker for the motion alarm qualifier, bound to the top level.
// Depends on maq_pkg for the mode encoding.
`default_nettype none

module maq_chk
  import maq_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [1:0] status_o,
  input wire logic       status_changed_o
);

  // Nothing is shown at the edge where reset is first seen released.
  a_reset_empty: assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

  // Input stalls only because a result is held back by the receiver.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  // Every beat leaves the uninitialized mode behind.
  a_never_uninit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o != MODE_UNINIT))
    else $error("result reports uninitialized mode");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(status_o) && $stable(status_changed_o)))
    else $error("stalled result changed");

endmodule : maq_chk

bind motion_alarm_qualifier_top maq_chk u_maq_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .status_o         (status_o),
  .status_changed_o (status_changed_o)
);

`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Testbench for motion_alarm_qualifier_top: a directed table, then random phases
// under several configurations, each result checked against a mode-machine predictor.
// Depends on maq_pkg and the block's RTL only.

module tb_top;
  import maq_pkg::*;

  localparam int unsigned SMP_W          = 10;
  localparam int unsigned SMP_MAX        = (1 << SMP_W) - 1;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned RAND_PHASES    = 8;
  localparam int unsigned PHASE_BEATS    = 200;
  localparam int unsigned DRAIN_CYCLES   = 4;
  localparam int unsigned LONG_HOLD      = 100;
  localparam int unsigned HOLD_AFTER     = 700;
  // The first register index that selects nothing; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_NONE = CFG_IDX_W'(2);
  localparam logic [IDLE_S_W-1:0]  IDLE_S_RESET = IDLE_S_W'(IDLE_MS_RESET / MS_PER_S);

  typedef enum logic {ROW_BEAT, ROW_WRITE} row_kind_e;

  // One line of the directed table: either a register write or an input beat,
  // the latter optionally with its result typed in by hand.
  typedef struct {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DAT_W-1:0] data;
    logic [SMP_W-1:0]     sample;
    logic [TIME_W-1:0]    now;
    bit                   typed;
    mode_e                status;
    logic                 changed;
  } row_t;

  // What one result beat must carry.
  typedef struct {
    mode_e status;
    logic  changed;
    bit    typed;
    mode_e t_status;
    logic  t_changed;
  } status_rec_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata_i   = '0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_stall_o;
  logic [SMP_W-1:0]     sample_i      = '0;
  logic [TIME_W-1:0]    now_ms_i      = '0;
  logic                 out_valid_o;
  logic                 out_stall_i   = 1'b0;
  logic [1:0]           status_o;
  logic                 status_changed_o;

  // Hand-typed expectation that travels alongside the beat on the input side.
  bit    beat_typed    = 1'b0;
  mode_e typed_status  = MODE_UNINIT;
  logic  typed_changed = 1'b0;

  // Predictor state: configuration and the mode machine.
  logic [THRESH_W-1:0] p_thresh = THRESH_RESET;
  logic [IDLE_S_W-1:0] p_idle_s = IDLE_S_RESET;
  mode_e               p_mode   = MODE_UNINIT;
  logic                p_level  = 1'b0;
  logic [TIME_W-1:0]   p_event  = '0;

  status_rec_t pending_status[$];
  int unsigned fail_count   = 0;
  int unsigned results_seen = 0;
  int unsigned quiet_cycles = 0;

  motion_alarm_qualifier_top #(
    .SAMPLE_BITS(SMP_W)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_i        (sample_i),
    .now_ms_i        (now_ms_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .status_changed_o(status_changed_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
  endfunction

  // Advances the predicted mode machine by one beat and returns the status
  // and change flag that the block must report for it.
  task automatic advance_mode(input logic [SMP_W-1:0] smp, input logic [TIME_W-1:0] t,
                              output mode_e st, output logic chg);
    logic              lvl;
    logic [TIME_W-1:0] elapsed;
    mode_e             was;
    lvl     = (smp > p_thresh);
    elapsed = t - p_event;  // wraps modulo 2^32 on purpose
    was     = p_mode;
    case (p_mode)
      MODE_UNINIT: begin
        p_level = lvl;
        p_event = t;
        p_mode  = MODE_STAB;
      end
      MODE_IDLE: begin
        if (lvl) begin
          p_level = 1'b1;
          p_event = t;
          p_mode  = MODE_ALARM;
        end
      end
      default: begin
        // Stabilizing and alarm share the same rule: a level change only
        // restarts the timer, a steady low level counts toward idle.
        if (lvl != p_level) begin
          p_event = t;
          p_level = lvl;
        end else if (!lvl && (elapsed / TIME_W'(MS_PER_S)) >= TIME_W'(p_idle_s)) begin
          p_mode = MODE_IDLE;
        end
      end
    endcase
    st  = p_mode;
    chg = (p_mode != was);
  endtask

  // All sampling happens here, at the rising edge. Results are checked before
  // the beat taken at the same edge is predicted, so the order stays obvious.
  always @(posedge clk_i) begin : track
    status_rec_t rec;
    mode_e       st;
    logic        chg;
    bit          bad;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (pending_status.size() == 0) begin
          note_failure($sformatf("result with nothing expected: status=%0d changed=%0d",
                                 status_o, status_changed_o));
        end else begin
          rec = pending_status.pop_front();
          bad = (status_o !== rec.status) || (status_changed_o !== rec.changed);
          if (rec.typed) begin
            bad = bad || (status_o !== rec.t_status) || (status_changed_o !== rec.t_changed);
          end
          if (bad) begin
            note_failure($sformatf(
              "result %0d: expected status=%0d changed=%0d%s, got status=%0d changed=%0d",
              results_seen, rec.status, rec.changed,
              rec.typed ? $sformatf(" (table says %0d/%0d)", rec.t_status, rec.t_changed) : "",
              status_o, status_changed_o));
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SENSE_THRESHOLD: p_thresh = cfg_wdata_i[THRESH_W-1:0];
          REG_IDLE_SECONDS:    p_idle_s = cfg_wdata_i[IDLE_S_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        advance_mode(sample_i, now_ms_i, st, chg);
        pending_status.push_back('{st, chg, beat_typed, typed_status, typed_changed});
      end
    end
  end

  // Watchdog: any accepted beat, taken result or register write counts as progress.
  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: random stall runs, calm stretches, and one long hold-off
  // that lets the block fill up and push back on the sender.
  initial begin : result_sink
    int unsigned run;
    int unsigned r;
    bit          hold_done;
    bit          stall_now;
    run       = 0;
    hold_done = 1'b0;
    stall_now = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        stall_now = 1'b1;
        run       = LONG_HOLD;
      end else if (run == 0) begin
        r = $urandom_range(99);
        if (r < 55) begin
          stall_now = 1'b0;
          run       = $urandom_range(6, 1);
        end else if (r < 85) begin
          stall_now = 1'b1;
          run       = $urandom_range(3, 1);
        end else if (r < 95) begin
          stall_now = 1'b0;
          run       = $urandom_range(150, 40);
        end else begin
          stall_now = 1'b1;
          run       = $urandom_range(30, 8);
        end
      end
      out_stall_i <= stall_now;
      run--;
    end
  end

  function automatic int unsigned sender_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  // A sample on the requested side of the live threshold. With the threshold at
  // its maximum no sample can be high, so any value is taken.
  function automatic logic [SMP_W-1:0] pick_sample(bit high);
    if (high && p_thresh != THRESH_W'(SMP_MAX)) begin
      return SMP_W'($urandom_range(SMP_MAX, int'(p_thresh) + 1));
    end
    if (!high) return SMP_W'($urandom_range(int'(p_thresh), 0));
    return SMP_W'($urandom_range(SMP_MAX, 0));
  endfunction

  // Presents one beat and returns at the edge where it is taken. Valid is left
  // high so a back-to-back beat needs only one update at the next falling edge.
  task automatic drive_beat(input logic [SMP_W-1:0] smp, input logic [TIME_W-1:0] t,
                            input bit typed, input mode_e st, input logic chg);
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    sample_i      <= smp;
    now_ms_i      <= t;
    beat_typed    <= typed;
    typed_status  <= st;
    typed_changed <= chg;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic idle_input(input int unsigned cycles);
    if (cycles != 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  // Stops sending and waits until every result is back, plus a few cycles,
  // so that register writes land while nothing is in flight.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic row_t beat_row(logic [SMP_W-1:0] s, logic [TIME_W-1:0] t);
    return '{ROW_BEAT, '0, '0, s, t, 1'b0, MODE_UNINIT, 1'b0};
  endfunction

  function automatic row_t known_row(logic [SMP_W-1:0] s, logic [TIME_W-1:0] t,
                                     mode_e st, logic chg);
    return '{ROW_BEAT, '0, '0, s, t, 1'b1, st, chg};
  endfunction

  function automatic row_t write_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    return '{ROW_WRITE, idx, data, '0, '0, 1'b0, MODE_UNINIT, 1'b0};
  endfunction

  initial begin : stimulus
    row_t                 rows[$];
    logic [CFG_DAT_W-1:0] thr_data;
    logic [CFG_DAT_W-1:0] idle_data;
    logic [TIME_W-1:0]    t;
    int unsigned          step_max;
    bit                   calm;
    bit                   lvl;

    // Reset values: threshold 200, ten seconds to idle.
    // The very first beat leaves the uninitialized mode whatever its level.
    rows.push_back(known_row(0, 0, MODE_STAB, 1'b1));
    rows.push_back(beat_row(0, 5000));
    rows.push_back(known_row(0, 10000, MODE_IDLE, 1'b1));
    // A sample equal to the threshold is still a low level.
    rows.push_back(known_row(200, 10001, MODE_IDLE, 1'b0));
    rows.push_back(known_row(201, 10002, MODE_ALARM, 1'b1));
    rows.push_back(known_row(SMP_W'(SMP_MAX), 10003, MODE_ALARM, 1'b0));
    // Falling level in alarm restarts the timer; idle needs ten full seconds.
    rows.push_back(beat_row(0, 10004));
    rows.push_back(beat_row(0, 20003));
    rows.push_back(known_row(0, 20004, MODE_IDLE, 1'b1));
    // Timer wrap: the event time sits at the top of the counter and now_ms
    // rolls over past zero.
    rows.push_back(known_row(SMP_W'(SMP_MAX), 32'hFFFF_FFFF, MODE_ALARM, 1'b1));
    rows.push_back(beat_row(0, 32'hFFFF_FFFF));
    rows.push_back(beat_row(0, 9998));
    rows.push_back(known_row(0, 9999, MODE_IDLE, 1'b1));
    // A time just before the event time reads as a very long wait.
    rows.push_back(known_row(SMP_W'(SMP_MAX), 32'h8000_0000, MODE_ALARM, 1'b1));
    rows.push_back(known_row(0, 32'h8000_0000, MODE_ALARM, 1'b0));
    rows.push_back(known_row(0, 32'h7FFF_FFFF, MODE_IDLE, 1'b1));
    // Zero idle time: the first unchanged low level goes straight to idle.
    rows.push_back(write_row(REG_IDLE_SECONDS, 16'h0000));
    rows.push_back(known_row(SMP_W'(SMP_MAX), 100, MODE_ALARM, 1'b1));
    rows.push_back(known_row(0, 100, MODE_ALARM, 1'b0));
    rows.push_back(known_row(0, 100, MODE_IDLE, 1'b1));
    // All-ones data masks to the largest threshold: nothing is above it.
    rows.push_back(write_row(REG_SENSE_THRESHOLD, 16'hFFFF));
    rows.push_back(known_row(SMP_W'(SMP_MAX), 200, MODE_IDLE, 1'b0));
    // Threshold zero: any nonzero sample is motion.
    rows.push_back(write_row(REG_SENSE_THRESHOLD, 16'h0000));
    rows.push_back(known_row(0, 300, MODE_IDLE, 1'b0));
    rows.push_back(known_row(1, 300, MODE_ALARM, 1'b1));
    // Longest idle time; the write to an unused index must not clear it.
    rows.push_back(write_row(REG_IDLE_SECONDS, 16'hFFFF));
    rows.push_back(write_row(REG_NONE, 16'h0000));
    rows.push_back(known_row(0, 301, MODE_ALARM, 1'b0));
    rows.push_back(beat_row(0, 301 + 65534999));
    rows.push_back(known_row(0, 301 + 65535000, MODE_IDLE, 1'b1));

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_WRITE) begin
        wait_drained();
        write_reg(rows[i].idx, rows[i].data);
      end else begin
        drive_beat(rows[i].sample, rows[i].now, rows[i].typed, rows[i].status,
                   rows[i].changed);
        idle_input(sender_gap());
      end
    end

    // Random phases. Time advances in steps scaled to the idle time so that
    // the machine keeps cycling through stabilizing, idle and alarm; a few
    // beats jump to an arbitrary time, which also exercises the wrap.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_drained();
      case (ph)
        1: begin
          thr_data  = 16'h0000;
          idle_data = 16'h0000;
        end
        2: begin
          thr_data  = 16'hFFFF;
          idle_data = 16'h0001;
        end
        3: begin
          thr_data  = CFG_DAT_W'($urandom_range(16'hFFFF, 0));
          idle_data = 16'hFFFF;
        end
        default: begin
          thr_data  = CFG_DAT_W'($urandom_range(16'hFFFF, 0));
          idle_data = CFG_DAT_W'($urandom_range(8, 0));
        end
      endcase
      write_reg(REG_SENSE_THRESHOLD, thr_data);
      write_reg(REG_IDLE_SECONDS, idle_data);
      if (ph >= 4) begin
        write_reg(CFG_IDX_W'($urandom_range(255, int'(REG_NONE))), CFG_DAT_W'($urandom()));
      end
      step_max = (int'(idle_data) + 1) * 600;
      t        = $urandom();
      calm     = (ph == 1 || ph == 5);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        lvl = ($urandom_range(99) < 20);
        if ($urandom_range(99) < 6) begin
          t = $urandom();
        end else begin
          t = t + TIME_W'($urandom_range(step_max, 0));
        end
        drive_beat(pick_sample(lvl), t, 1'b0, MODE_UNINIT, 1'b0);
        if (!calm) idle_input(sender_gap());
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_status.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", pending_status.size()));
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
